// ----- sv/rrwl_pkg.sv -----
package rrwl_pkg;

  // Sizes of the lock table and the counters.
  localparam int NUM_THREADS = 16;
  localparam int DEPTH_BITS  = 8;
  localparam int OP_W        = 3;
  localparam int TID_W       = 4;
  localparam int ST_W        = 2;
  localparam int TBL_DEPTH   = 2 ** TID_W;
  localparam int AR_W        = $clog2(NUM_THREADS + 1);

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOCK        = 3'd0;
  localparam logic [OP_W-1:0] OP_LOCK_SHARED = 3'd1;
  localparam logic [OP_W-1:0] OP_UNLOCK      = 3'd2;
  localparam logic [OP_W-1:0] OP_UNLOCK_SHRD = 3'd3;
  localparam logic [OP_W-1:0] OP_TRY_LOCK    = 3'd4;
  localparam logic [OP_W-1:0] OP_TRY_SHARED  = 3'd5;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_REFUSED = 2'd1;
  localparam logic [ST_W-1:0] ST_WAIT    = 2'd2;
  localparam logic [ST_W-1:0] ST_ERROR   = 2'd3;

  // One result word.
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [TID_W-1:0] target;
    logic             last;
  } res_t;

  // Access to the reader depth table.
  typedef struct packed {
    logic                  rd_en;
    logic [TID_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [TID_W-1:0]      wr_addr;
    logic [DEPTH_BITS-1:0] wr_data;
  } mem_req_t;

  // Results handed to the output buffer.
  typedef struct packed {
    logic push;
    logic two;
    res_t r0;
    res_t r1;
  } push_t;

endpackage

// ----- sv/recursive_rw_lock_manager_unit.sv -----
// Recursive reader-writer lock manager with writer priority.
// Input channel: in_valid_i / in_stall_o carry one request word (op_code_i,
// requester_i). A word is taken at a clock edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i carry result words (status_o,
// target_o, last_o); last_o marks the final word of a request. A release that
// lets a pending writer in yields two words: the release, then the writer's
// grant.
// Each request has two steps: a read of the reader depth entry from the table
// memory, then a decision that writes the entry back. The first result word
// is registered into the output buffer when the decision is made. A new
// request is taken only after the previous one has made its decision, and
// in_stall_o stays high until then.
// The output buffer holds up to two words. A new request may be taken while
// results wait, but its update waits until the buffer has drained, so a
// stalling receiver holds off further requests through in_stall_o.
// Reset clears the writer registers, the reader count, the output buffer and
// the table's valid bits at once, so the table reads as all zero; no clearing
// pass is needed and a request can be taken as soon as reset is released.
module recursive_rw_lock_manager_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [rrwl_pkg::OP_W-1:0]       op_code_i,
  input  logic [rrwl_pkg::TID_W-1:0]      requester_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rrwl_pkg::ST_W-1:0]       status_o,
  output logic [rrwl_pkg::TID_W-1:0]      target_o,
  output logic                            last_o
);
  import rrwl_pkg::*;

  mem_req_t              mem_req;
  logic [DEPTH_BITS-1:0] mem_depth;
  push_t                 push;
  logic                  obuf_empty;

  // Reader depth table.
  rrwl_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (mem_depth)
  );

  // Request sequencer and lock state.
  rrwl_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_code_i    (op_code_i),
    .requester_i  (requester_i),
    .mem_req_o    (mem_req),
    .mem_depth_i  (mem_depth),
    .obuf_empty_i (obuf_empty),
    .push_o       (push)
  );

  // Result word buffer.
  rrwl_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .empty_o     (obuf_empty),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .target_o    (target_o),
    .last_o      (last_o)
  );

endmodule

// ----- sv/rrwl_mem.sv -----
module rrwl_mem (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rrwl_pkg::mem_req_t                 req_i,
  output logic [rrwl_pkg::DEPTH_BITS-1:0]    rd_data_o
);
  import rrwl_pkg::*;

  logic [DEPTH_BITS-1:0] mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0]  vld_q;
  logic [DEPTH_BITS-1:0] rd_q;
  logic                  rd_vld_q;

  // Storage array and its registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  // Valid bits make the table read as zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// ----- sv/rrwl_obuf.sv -----
module rrwl_obuf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rrwl_pkg::push_t               push_i,
  output logic                          empty_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rrwl_pkg::ST_W-1:0]     status_o,
  output logic [rrwl_pkg::TID_W-1:0]    target_o,
  output logic                          last_o
);
  import rrwl_pkg::*;

  res_t       slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop = out_valid_o && !out_stall_i;

  // Two-word queue; the core only loads it when it is empty.
  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q;
    if (push_i.push) begin
      slot0_d = push_i.r0;
      slot1_d = push_i.r1;
      cnt_d   = push_i.two ? 2'd2 : 2'd1;
    end else if (pop) begin
      slot0_d = slot1_q;
      cnt_d   = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign empty_o     = (cnt_q == 2'd0);
  assign out_valid_o = (cnt_q != 2'd0);
  assign status_o    = slot0_q.status;
  assign target_o    = slot0_q.target;
  assign last_o      = slot0_q.last;

endmodule

// ----- sv/rrwl_core.sv -----
module rrwl_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rrwl_pkg::OP_W-1:0]         op_code_i,
  input  logic [rrwl_pkg::TID_W-1:0]        requester_i,
  output rrwl_pkg::mem_req_t                mem_req_o,
  input  logic [rrwl_pkg::DEPTH_BITS-1:0]   mem_depth_i,
  input  logic                              obuf_empty_i,
  output rrwl_pkg::push_t                   push_o
);
  import rrwl_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                  state_q, state_d;
  logic [OP_W-1:0]       op_q;
  logic [TID_W-1:0]      req_q;
  logic                  wv_q, wv_d;
  logic [TID_W-1:0]      wid_q, wid_d;
  logic [DEPTH_BITS-1:0] wdep_q, wdep_d;
  logic                  pend_q, pend_d;
  logic [AR_W-1:0]       ar_q, ar_d, ar_dec;
  logic                  accept, fire;
  logic                  is_w, wa_err, in_range;
  logic [ST_W-1:0]       st;
  logic                  two;
  logic                  tbl_we;
  logic [DEPTH_BITS-1:0] tbl_wd;
  logic [DEPTH_BITS-1:0] rd;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign fire       = (state_q == S_EXEC) && obuf_empty_i;
  assign rd         = mem_depth_i;

  // Sequencer: read the table entry, then update once the output is free.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Lock decision for the captured request.
  assign is_w     = wv_q && (wid_q == req_q);
  assign wa_err   = pend_q || (wdep_q == DEPTH_MAX);
  assign in_range = (32'(req_q) < NUM_THREADS);
  assign ar_dec   = (ar_q != '0) ? ar_q - 1'b1 : ar_q;

  always_comb begin
    st     = ST_ERROR;
    two    = 1'b0;
    wv_d   = wv_q;
    wid_d  = wid_q;
    wdep_d = wdep_q;
    pend_d = pend_q;
    ar_d   = ar_q;
    tbl_we = 1'b0;
    tbl_wd = rd;
    if (!in_range || (op_q > OP_TRY_SHARED)) begin
      st = ST_ERROR;
    end else begin
      case (op_q)
        OP_LOCK: begin
          if (is_w) begin
            if (!wa_err) begin
              wdep_d = wdep_q + 1'b1;
              st     = ST_OK;
            end
          end else if (rd != '0) begin
            st = ST_ERROR;
          end else if (wv_q) begin
            st = ST_WAIT;
          end else begin
            wv_d   = 1'b1;
            wid_d  = req_q;
            wdep_d = DEPTH_BITS'(1);
            if (ar_q != '0) begin
              pend_d = 1'b1;
              st     = ST_WAIT;
            end else begin
              st = ST_OK;
            end
          end
        end
        OP_LOCK_SHARED: begin
          if (is_w) begin
            if (!wa_err) begin
              wdep_d = wdep_q + 1'b1;
              st     = ST_OK;
            end
          end else if (rd != '0) begin
            if (rd != DEPTH_MAX) begin
              tbl_we = 1'b1;
              tbl_wd = rd + 1'b1;
              st     = ST_OK;
            end
          end else if (wv_q) begin
            st = ST_WAIT;
          end else begin
            tbl_we = 1'b1;
            tbl_wd = DEPTH_BITS'(1);
            ar_d   = ar_q + 1'b1;
            st     = ST_OK;
          end
        end
        OP_UNLOCK: begin
          if (is_w && !pend_q) begin
            if (wdep_q > DEPTH_BITS'(1)) begin
              wdep_d = wdep_q - 1'b1;
            end else begin
              wv_d   = 1'b0;
              wid_d  = '0;
              wdep_d = '0;
            end
            st = ST_OK;
          end
        end
        OP_UNLOCK_SHRD: begin
          if (is_w) begin
            if (!pend_q && (wdep_q > DEPTH_BITS'(1))) begin
              wdep_d = wdep_q - 1'b1;
              st     = ST_OK;
            end
          end else if (rd == '0) begin
            st = ST_ERROR;
          end else if (rd > DEPTH_BITS'(1)) begin
            tbl_we = 1'b1;
            tbl_wd = rd - 1'b1;
            st     = ST_OK;
          end else begin
            // Last reader of this thread leaves; a pending writer may now go.
            tbl_we = 1'b1;
            tbl_wd = '0;
            ar_d   = ar_dec;
            st     = ST_OK;
            if (pend_q && (ar_dec == '0)) begin
              pend_d = 1'b0;
              two    = 1'b1;
            end
          end
        end
        OP_TRY_LOCK: begin
          if (is_w) begin
            if (!wa_err) begin
              wdep_d = wdep_q + 1'b1;
              st     = ST_OK;
            end
          end else if (!wv_q && (ar_q == '0)) begin
            wv_d   = 1'b1;
            wid_d  = req_q;
            wdep_d = DEPTH_BITS'(1);
            st     = ST_OK;
          end else begin
            st = ST_REFUSED;
          end
        end
        OP_TRY_SHARED: begin
          if (is_w) begin
            if (!wa_err) begin
              wdep_d = wdep_q + 1'b1;
              st     = ST_OK;
            end
          end else if (!wv_q) begin
            if (rd != DEPTH_MAX) begin
              if (rd == '0) begin
                ar_d = ar_q + 1'b1;
              end
              tbl_we = 1'b1;
              tbl_wd = rd + 1'b1;
              st     = ST_OK;
            end
          end else begin
            st = ST_REFUSED;
          end
        end
        default: st = ST_ERROR;
      endcase
    end
  end

  // Table port: read on accept, write back when the request completes.
  always_comb begin
    mem_req_o.rd_en   = accept;
    mem_req_o.rd_addr = requester_i;
    mem_req_o.wr_en   = fire && tbl_we;
    mem_req_o.wr_addr = req_q;
    mem_req_o.wr_data = tbl_wd;
  end

  // Result words for the output buffer.
  always_comb begin
    push_o.push      = fire;
    push_o.two       = two;
    push_o.r0.status = st;
    push_o.r0.target = req_q;
    push_o.r0.last   = !two;
    push_o.r1.status = ST_OK;
    push_o.r1.target = wid_q;
    push_o.r1.last   = 1'b1;
  end

  // Control and writer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wv_q    <= 1'b0;
      wid_q   <= '0;
      wdep_q  <= '0;
      pend_q  <= 1'b0;
      ar_q    <= '0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        wv_q   <= wv_d;
        wid_q  <= wid_d;
        wdep_q <= wdep_d;
        pend_q <= pend_d;
        ar_q   <= ar_d;
      end
    end
  end

  // Captured request word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_code_i;
      req_q <= requester_i;
    end
  end

endmodule
